// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL. All checks are sampled on aclk and
// are switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every sampled clock edge.
`define PKITA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define PKITA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define PKITA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pkita_pkg.sv -----
package pkita_pkg;

    localparam int START_SLOTS = 16;
    localparam int IFACE_SLOTS = 16;
    localparam int PHASE_COUNT = 4;

    localparam int SS_W = (START_SLOTS > 1) ? $clog2(START_SLOTS) : 1;
    localparam int IS_W = (IFACE_SLOTS > 1) ? $clog2(IFACE_SLOTS) : 1;
    localparam int PH_W = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
    // Counter selector: the phases plus the total counter.
    localparam int CP_W = $clog2(PHASE_COUNT + 1);

    typedef enum logic [1:0] {
        REQ_ENTRY  = 2'd0,
        REQ_RETURN = 2'd1,
        REQ_READ   = 2'd2,
        REQ_UNUSED = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSTART = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOKEY   = 2'd3
    } status_t;

    typedef struct packed {
        logic            hit;
        logic [SS_W-1:0] hit_idx;
        logic            free;
        logic [SS_W-1:0] free_idx;
        logic [63:0]     time_ns;
        logic [31:0]     iface;
    } start_look_t;

    typedef struct packed {
        logic            wr;
        logic            clr;
        logic [PH_W-1:0] phase;
        logic [SS_W-1:0] idx;
        logic [63:0]     thread;
        logic [63:0]     time_ns;
        logic [31:0]     iface;
    } start_upd_t;

    typedef struct packed {
        logic            hit;
        logic            free;
        logic [IS_W-1:0] slot;
        logic [63:0]     cnt_sel;
        logic [63:0]     cnt_total;
    } acc_look_t;

    typedef struct packed {
        logic            wr;
        logic            alloc;
        logic [IS_W-1:0] slot;
        logic [31:0]     key;
        logic [CP_W-1:0] phase;
        logic [63:0]     cnt_phase;
        logic [63:0]     cnt_total;
    } acc_upd_t;

endpackage

// ----- rtl/core/pkita_start_table.sv -----
module pkita_start_table
    import pkita_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [PH_W-1:0] look_phase,
    input  logic [63:0]     look_thread,
    output start_look_t     look,
    input  start_upd_t      upd
);

    logic [PHASE_COUNT-1:0][START_SLOTS-1:0] valid_reg;
    logic [63:0] thread_reg [PHASE_COUNT][START_SLOTS];
    logic [63:0] time_reg   [PHASE_COUNT][START_SLOTS];
    logic [31:0] iface_reg  [PHASE_COUNT][START_SLOTS];

    // Tag compare across the selected phase row; the lowest index wins.
    always_comb begin
        look.hit      = 1'b0;
        look.hit_idx  = '0;
        look.free     = 1'b0;
        look.free_idx = '0;
        for (int i = START_SLOTS - 1; i >= 0; i--) begin
            if (valid_reg[look_phase][i] && thread_reg[look_phase][i] == look_thread) begin
                look.hit     = 1'b1;
                look.hit_idx = SS_W'(i);
            end
            if (!valid_reg[look_phase][i]) begin
                look.free     = 1'b1;
                look.free_idx = SS_W'(i);
            end
        end
        look.time_ns = time_reg[look_phase][look.hit_idx];
        look.iface   = iface_reg[look_phase][look.hit_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (upd.wr) begin
            valid_reg[upd.phase][upd.idx] <= 1'b1;
        end else if (upd.clr) begin
            valid_reg[upd.phase][upd.idx] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.wr) begin
            thread_reg[upd.phase][upd.idx] <= upd.thread;
            time_reg[upd.phase][upd.idx]   <= upd.time_ns;
            iface_reg[upd.phase][upd.idx]  <= upd.iface;
        end
    end

endmodule

// ----- rtl/core/pkita_acc_table.sv -----
module pkita_acc_table
    import pkita_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [31:0]     look_key,
    input  logic [CP_W-1:0] look_phase,
    output acc_look_t       look,
    input  acc_upd_t        upd
);

    logic [IFACE_SLOTS-1:0] valid_reg;
    logic [31:0]            iface_reg [IFACE_SLOTS];
    // Per slot: one counter for each phase, then the total.
    logic [PHASE_COUNT:0][63:0] cnt_reg [IFACE_SLOTS];

    logic            hit;
    logic [IS_W-1:0] hit_idx;
    logic            free;
    logic [IS_W-1:0] free_idx;
    logic [IS_W-1:0] slot;

    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free     = 1'b0;
        free_idx = '0;
        for (int i = IFACE_SLOTS - 1; i >= 0; i--) begin
            if (valid_reg[i] && iface_reg[i] == look_key) begin
                hit     = 1'b1;
                hit_idx = IS_W'(i);
            end
            if (!valid_reg[i]) begin
                free     = 1'b1;
                free_idx = IS_W'(i);
            end
        end
        slot = hit ? hit_idx : free_idx;

        look.hit       = hit;
        look.free      = free;
        look.slot      = slot;
        look.cnt_sel   = '0;
        look.cnt_total = '0;
        // A freshly allocated slot reads as zero.
        if (hit) begin
            for (int j = 0; j <= PHASE_COUNT; j++) begin
                if (look_phase == CP_W'(j)) begin
                    look.cnt_sel = cnt_reg[hit_idx][j];
                end
            end
            look.cnt_total = cnt_reg[hit_idx][PHASE_COUNT];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (upd.wr) begin
            valid_reg[upd.slot] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.wr) begin
            if (upd.alloc) begin
                iface_reg[upd.slot] <= upd.key;
            end
            for (int j = 0; j < PHASE_COUNT; j++) begin
                if (upd.phase == CP_W'(j)) begin
                    cnt_reg[upd.slot][j] <= upd.cnt_phase;
                end else if (upd.alloc) begin
                    cnt_reg[upd.slot][j] <= '0;
                end
            end
            cnt_reg[upd.slot][PHASE_COUNT] <= upd.cnt_total;
        end
    end

endmodule

// ----- rtl/core/per_key_interval_time_accounting_core.sv -----
// Per-interface interval accounting. Each request (entry, return or read,
// tagged with a processing phase) produces exactly one result transfer.
// The block takes one request per clock cycle while the result side is not
// stalled: a request sits in the input register, goes through tag compare
// over the start and counter tables plus one 64-bit subtract and two adds,
// and lands in the result register. All tables live in flip-flops with valid
// bits cleared by reset, so the block is ready right after reset with no
// clearing pass. A stall on the result side holds the input register; up
// to two requests are buffered.
`include "assert_macros.svh"

module per_key_interval_time_accounting_core
    import pkita_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,  // thread_id[63:0], if_index[95:64], now_ns[159:96]
    input  logic [4:0]   s_tuser,  // req_type[1:0], phase[4:2]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // delta_ns[63:0], counter_value[127:64]
    output logic [1:0]   m_tuser   // status[1:0]
);

    logic        in_valid_reg;
    req_t        req_reg;
    logic [2:0]  phase_reg;
    logic [63:0] thread_reg;
    logic [31:0] iface_reg;
    logic [63:0] now_reg;

    logic        m_valid_reg;
    status_t     status_reg;
    logic [63:0] delta_reg;
    logic [63:0] cval_reg;

    logic        advance;
    logic        fire;
    logic        ph_ok;
    logic        rd_ok;
    start_look_t slook;
    start_upd_t  supd;
    acc_look_t   alook;
    acc_upd_t    aupd;
    logic [31:0] acc_key;
    status_t     status_next;
    logic [63:0] delta_next;
    logic [63:0] cval_next;

    assign advance  = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign ph_ok   = ({1'b0, phase_reg} < 4'(PHASE_COUNT));
    assign rd_ok   = ({1'b0, phase_reg} <= 4'(PHASE_COUNT));
    assign acc_key = (req_reg == REQ_RETURN) ? slook.iface : iface_reg;

    pkita_start_table u_start (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .look_phase  (PH_W'(phase_reg)),
        .look_thread (thread_reg),
        .look        (slook),
        .upd         (supd)
    );

    pkita_acc_table u_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .look_key   (acc_key),
        .look_phase (CP_W'(phase_reg)),
        .look       (alook),
        .upd        (aupd)
    );

    always_comb begin
        status_next = ST_OK;
        delta_next  = '0;
        cval_next   = '0;

        supd         = '0;
        supd.phase   = PH_W'(phase_reg);
        supd.thread  = thread_reg;
        supd.time_ns = now_reg;
        supd.iface   = iface_reg;

        aupd       = '0;
        aupd.slot  = alook.slot;
        aupd.key   = acc_key;
        aupd.phase = CP_W'(phase_reg);

        unique case (req_reg)
            REQ_ENTRY: begin
                if (!ph_ok || (!slook.hit && !slook.free)) begin
                    status_next = ST_FULL;
                end else begin
                    supd.wr  = fire;
                    supd.idx = slook.hit ? slook.hit_idx : slook.free_idx;
                end
            end
            REQ_RETURN: begin
                if (!ph_ok || !slook.hit) begin
                    status_next = ST_NOSTART;
                end else if (!alook.hit && !alook.free) begin
                    status_next = ST_FULL;
                end else begin
                    delta_next     = now_reg - slook.time_ns;
                    cval_next      = alook.cnt_sel + delta_next;
                    aupd.wr        = fire;
                    aupd.alloc     = !alook.hit;
                    aupd.cnt_phase = cval_next;
                    aupd.cnt_total = alook.cnt_total + delta_next;
                    supd.clr       = fire;
                    supd.idx       = slook.hit_idx;
                end
            end
            REQ_READ: begin
                if (!rd_ok || !alook.hit) begin
                    status_next = ST_NOKEY;
                end else begin
                    cval_next = alook.cnt_sel;
                end
            end
            default: begin
                status_next = ST_FULL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg    <= req_t'(s_tuser[1:0]);
            phase_reg  <= s_tuser[4:2];
            thread_reg <= s_tdata[63:0];
            iface_reg  <= s_tdata[95:64];
            now_reg    <= s_tdata[159:96];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg <= status_next;
            delta_reg  <= delta_next;
            cval_reg   <= cval_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {cval_reg, delta_reg};
    assign m_tuser  = status_reg;

    // A request that cannot move on keeps its place in the input register.
    `PKITA_ASSERT_NEXT(a_hold_stalled, in_valid_reg && !advance,
                       in_valid_reg && $stable(thread_reg), "stalled request lost")
    // Every processed request shows up as a result transfer in the next cycle.
    `PKITA_ASSERT_NEXT(a_fire_result, fire, m_valid_reg, "processed request produced no result")
    // Back-pressure on the input only when both registers are occupied.
    `PKITA_ASSERT(a_ready_full, s_tready || (in_valid_reg && m_valid_reg),
                  "input stalled with free space")
    // Only a successful return carries an interval.
    `PKITA_ASSERT_SAME(a_delta_ok, m_valid_reg && status_reg != ST_OK,
                       delta_reg == 64'd0, "interval on failed request")

endmodule
